// ===== rtl/core/phr_pkg.sv =====
// Package for the pixel hit resolve block: register codes, configuration
// struct and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package phr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIST_W        = 32;
  localparam int COL_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int SUM_W         = 48;
  localparam int SUM_FRAC      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 3'd0,
    REG_CONC = 3'd1,
    REG_LOSS = 3'd2,
    REG_MAXC = 3'd3
  } phr_reg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] conc;
    logic [15:0] loss;
    logic [7:0]  maxc;
  } phr_cfg_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic acc;
    logic emit;
  } phr_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } phr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/phr_cfg_regs.sv =====
// Configuration register file of the pixel hit resolve block.
// Depends on phr_pkg for the register codes and the configuration struct.
`default_nettype none

module phr_cfg_regs
  import phr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output phr_cfg_t                   cfg
);

  phr_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (phr_reg_t'(cfg_index))
        REG_MODE: cfg_nxt.mode = cfg_data[0];
        REG_CONC: cfg_nxt.conc = cfg_data;
        REG_LOSS: cfg_nxt.loss = cfg_data;
        REG_MAXC: cfg_nxt.maxc = cfg_data[7:0];
        default:  cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= 1'b0;
      cfg_r.conc <= 16'd256;
      cfg_r.loss <= 16'd655;
      cfg_r.maxc <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/phr_ctrl.sv =====
// Controller state machine of the pixel hit resolve block. Sequences one
// record through load, two multiply steps, accumulate and finish. Uses phr_pkg.
`default_nettype none

module phr_ctrl
  import phr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire phr_sts_t sts,
  output phr_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ACC;
      S_ACC:  state_nxt = S_FIN;
      // A last record waits here while the previous result is still unread.
      S_FIN:  if (!(sts.last && sts.out_busy)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  always_comb begin
    cmd      = '0;
    cmd.load = in_valid && in_ready_r;
    cmd.mul1 = (state_r == S_MUL1);
    cmd.mul2 = (state_r == S_MUL2);
    cmd.acc  = (state_r == S_ACC);
    cmd.emit = (state_r == S_FIN) && sts.last && !sts.out_busy;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("in_ready outside idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_MUL1)
    else $error("accepted record did not start");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && sts.last && sts.out_busy |=> state_r == S_FIN)
    else $error("last record left finish while output busy");

endmodule

`default_nettype wire

// ===== rtl/core/phr_datapath.sv =====
// Datapath of the pixel hit resolve block: input capture, nearest-hit
// tracking, three-lane transparency arithmetic and the result register.
// Uses phr_pkg; driven by commands from phr_ctrl.
`default_nettype none

module phr_datapath
  import phr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire phr_cfg_t                 cfg,
  input  wire phr_cmd_t                 cmd,
  output phr_sts_t                      sts,
  input  wire logic signed [DIST_W-1:0] in_entry_dist,
  input  wire logic signed [DIST_W-1:0] in_exit_dist,
  input  wire logic [COL_W-1:0]         in_obj_red,
  input  wire logic [COL_W-1:0]         in_obj_green,
  input  wire logic [COL_W-1:0]         in_obj_blue,
  input  wire logic                     in_last_obj,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [COL_W-1:0]              out_red,
  output logic [COL_W-1:0]              out_green,
  output logic [COL_W-1:0]              out_blue,
  output logic [DIST_W-2:0]             out_depth,
  output logic                          out_any_hit
);

  localparam int P1_W   = 26;                // 9-bit signed diff times 17-bit signed ratio
  localparam int THK_W  = DIST_W + 1;
  localparam int P2_W   = P1_W + THK_W;
  localparam int LOSS_W = P2_W - FRAC_BITS;
  localparam int ACC_W  = ((LOSS_W > SUM_W) ? LOSS_W : SUM_W) + 2;

  // Captured record.
  logic signed [DIST_W-1:0]  entry_r, exit_r;
  logic [2:0][COL_W-1:0]     col_r;
  logic                      last_r;

  // Arithmetic pipeline registers.
  logic                      hit_r;
  logic signed [THK_W-1:0]   thick_r;
  logic signed [P1_W-1:0]    p1_r [3];
  logic [23:0]               gain_r [3];
  logic signed [P2_W-1:0]    p2_r [3];

  // Per-pixel state.
  logic signed [DIST_W-1:0]  nearest_r;
  logic [2:0][COL_W-1:0]     ncol_r;
  logic                      seen_r;
  logic signed [SUM_W-1:0]   sum_r [3];
  logic signed [SUM_W-1:0]   sum_nxt [3];

  // Result register.
  logic                      out_valid_r;
  logic [2:0][COL_W-1:0]     out_col_r;
  logic [DIST_W-2:0]         out_depth_r;
  logic                      out_hit_r;
  logic [2:0][COL_W-1:0]     res_col;

  logic                      is_hit;
  logic                      nearer;

  assign is_hit = (entry_r > 0);
  assign nearer = !seen_r || (entry_r < nearest_r);

  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_r  <= in_entry_dist;
      exit_r   <= in_exit_dist;
      col_r[0] <= in_obj_red;
      col_r[1] <= in_obj_green;
      col_r[2] <= in_obj_blue;
      last_r   <= in_last_obj;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      hit_r   <= is_hit;
      thick_r <= THK_W'(exit_r) - THK_W'(entry_r);
      for (int c = 0; c < 3; c++) begin
        p1_r[c]   <= P1_W'($signed({1'b0, cfg.maxc}) - $signed({1'b0, col_r[c]}))
                     * P1_W'($signed({1'b0, cfg.loss}));
        gain_r[c] <= 24'(col_r[c] * cfg.conc);
      end
    end
    if (cmd.mul2) begin
      for (int c = 0; c < 3; c++) begin
        p2_r[c] <= P2_W'(p1_r[c]) * P2_W'(thick_r);
      end
    end
  end

  // Accumulate gain minus floored loss, saturating to the signed sum range.
  always_comb begin
    logic signed [P2_W-1:0]  loss_full;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-SUM_W:0]    upper;
    for (int c = 0; c < 3; c++) begin
      loss_full = p2_r[c] >>> FRAC_BITS;
      acc = ACC_W'(sum_r[c])
          + $signed(ACC_W'({gain_r[c], 8'd0}))
          - ACC_W'($signed(loss_full[LOSS_W-1:0]));
      upper = acc[ACC_W-1:SUM_W-1];
      if (upper == '0 || upper == '1) begin
        sum_nxt[c] = acc[SUM_W-1:0];
      end else if (acc[ACC_W-1]) begin
        sum_nxt[c] = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sum_nxt[c] = {1'b0, {(SUM_W-1){1'b1}}};
      end
    end
  end

  // Final channel values for the result.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!seen_r) begin
        res_col[c] = '0;
      end else if (!cfg.mode) begin
        res_col[c] = ncol_r[c];
      end else if (sum_r[c][SUM_W-1]) begin
        res_col[c] = '0;
      end else if (sum_r[c][SUM_W-2:SUM_FRAC+COL_W] != '0) begin
        res_col[c] = '1;
      end else begin
        res_col[c] = sum_r[c][SUM_FRAC+COL_W-1:SUM_FRAC];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= 1'b0;
      nearest_r <= '0;
      ncol_r    <= '0;
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
    end else if (cmd.emit) begin
      seen_r    <= 1'b0;
      nearest_r <= '0;
      ncol_r    <= '0;
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
    end else begin
      if (cmd.mul1 && is_hit) begin
        seen_r <= 1'b1;
        if (nearer) begin
          nearest_r <= entry_r;
          ncol_r    <= col_r;
        end
      end
      if (cmd.acc && hit_r) begin
        for (int c = 0; c < 3; c++) sum_r[c] <= sum_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_col_r   <= res_col;
      out_depth_r <= seen_r ? nearest_r[DIST_W-2:0] : '0;
      out_hit_r   <= seen_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_col_r[0];
  assign out_green   = out_col_r[1];
  assign out_blue    = out_col_r[2];
  assign out_depth   = out_depth_r;
  assign out_any_hit = out_hit_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && !seen_r)
    else $error("emit did not raise result or clear pixel");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_depth_r == '0 && out_col_r == '0)
    else $error("result without hit carries nonzero fields");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result overwritten while unread");

endmodule

`default_nettype wire

// ===== rtl/core/pixel_hit_resolve.sv =====
// Top level of the pixel hit resolve block: configuration registers,
// controller and datapath. Depends on phr_pkg, phr_cfg_regs, phr_ctrl and
// phr_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | entry_dist, exit_dist, obj rgb, last_obj
//   out     | out_valid / out_ready| red, green, blue, depth, any_hit
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each record passes through capture, two multiply steps (ratio by colour
// difference, then by the thickness), accumulate with saturation, and finish
// before the next record can be taken.
// A last record stays in finish while the previous result is unread; the
// result register otherwise lets the next record in while a result waits.
// Reset is synchronous; it clears the pixel state and loads register defaults.
`default_nettype none

module pixel_hit_resolve
  import phr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DIST_W-1:0] in_entry_dist,
  input  wire logic signed [DIST_W-1:0] in_exit_dist,
  input  wire logic [COL_W-1:0]         in_obj_red,
  input  wire logic [COL_W-1:0]         in_obj_green,
  input  wire logic [COL_W-1:0]         in_obj_blue,
  input  wire logic                     in_last_obj,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [COL_W-1:0]              out_red,
  output logic [COL_W-1:0]              out_green,
  output logic [COL_W-1:0]              out_blue,
  output logic [DIST_W-2:0]             out_depth,
  output logic                          out_any_hit,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  phr_cfg_t cfg;
  phr_cmd_t cmd;
  phr_sts_t sts;

  phr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  phr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_entry_dist (in_entry_dist),
    .in_exit_dist  (in_exit_dist),
    .in_obj_red    (in_obj_red),
    .in_obj_green  (in_obj_green),
    .in_obj_blue   (in_obj_blue),
    .in_last_obj   (in_last_obj),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_depth     (out_depth),
    .out_any_hit   (out_any_hit)
  );

endmodule

`default_nettype wire

// ===== tb/pixel_hit_resolve_test.sv =====
// Self-checking testbench for pixel_hit_resolve: a directed table, then random pixel runs
// under several register settings, each result checked against its typed expectation or an in-bench model.
// Depends on phr_pkg and the pixel_hit_resolve RTL.
module pixel_hit_resolve_test;
  timeunit 1ns;
  timeprecision 1ps;
  import phr_pkg::*;

  localparam int     QUIET_CYCLES = 16;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     SAT_UP       = 140;
  localparam int     SAT_DOWN     = 270;
  localparam longint SUM_HI       = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO       = -SUM_HI - 1;

  typedef struct packed {
    logic [DIST_W-1:0] near;
    logic [DIST_W-1:0] far;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic              last;
  } hit_rec_t;

  typedef struct packed {
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [DIST_W-2:0] depth;
    logic              hit;
  } pixel_t;

  typedef struct packed {
    bit       set_regs;
    phr_cfg_t regs;
    hit_rec_t rec;
    bit       typed;
    pixel_t   want;
  } plan_row_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [DIST_W-1:0]     in_entry_dist = '0;
  logic [DIST_W-1:0]     in_exit_dist  = '0;
  logic [COL_W-1:0]      in_obj_red    = '0;
  logic [COL_W-1:0]      in_obj_green  = '0;
  logic [COL_W-1:0]      in_obj_blue   = '0;
  logic                  in_last_obj   = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [COL_W-1:0]      out_red;
  logic [COL_W-1:0]      out_green;
  logic [COL_W-1:0]      out_blue;
  logic [DIST_W-2:0]     out_depth;
  logic                  out_any_hit;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Model state: register copy plus the per-pixel accumulators.
  phr_cfg_t           regs;
  logic signed [31:0] near_dist;
  logic [23:0]        near_rgb;
  bit                 hit_seen;
  longint             chan_sum [3];

  pixel_t      pending_pixels [$];
  plan_row_t   plan_rows [$];
  int          errors       = 0;
  int          cycles       = 0;
  bit          calm         = 1'b0;
  int          stall_asked  = 0;
  int          stall_served = 0;
  int          hold_left    = 0;

  pixel_hit_resolve u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_entry_dist(in_entry_dist),
    .in_exit_dist (in_exit_dist),
    .in_obj_red   (in_obj_red),
    .in_obj_green (in_obj_green),
    .in_obj_blue  (in_obj_blue),
    .in_last_obj  (in_last_obj),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_depth    (out_depth),
    .out_any_hit  (out_any_hit),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 13);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h", what, cycles, got,
             want);
  endtask

  task automatic clear_pixel_state();
    near_dist = '0;
    near_rgb  = '0;
    hit_seen  = 1'b0;
    foreach (chan_sum[c]) chan_sum[c] = 0;
  endtask

  function automatic logic [COL_W-1:0] clamp_channel(input longint s);
    longint v;
    if (s < 0) return '0;
    v = s >>> SUM_FRAC;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // Folds one record into the pixel; returns 1 with the resolved pixel on a last record.
  task automatic resolve_record(input hit_rec_t h, output bit emits, output pixel_t px);
    logic [COL_W-1:0] col [3];
    longint ne, fa, thick, gain, diff, loss, s;
    col[0] = h.red;
    col[1] = h.green;
    col[2] = h.blue;
    px     = '0;
    if ($signed(h.near) > 0) begin
      // Ties keep the first record that reached the distance.
      if (!hit_seen || $signed(h.near) < near_dist) begin
        near_dist = h.near;
        near_rgb  = {h.red, h.green, h.blue};
      end
      hit_seen = 1'b1;
      ne    = longint'($signed(h.near));
      fa    = longint'($signed(h.far));
      thick = fa - ne;
      for (int c = 0; c < 3; c++) begin
        gain = longint'(col[c]) * longint'(regs.conc) * 256;
        diff = longint'(regs.maxc) - longint'(col[c]);
        // Arithmetic shift of a signed value rounds toward minus infinity.
        loss = (diff * longint'(regs.loss) * thick) >>> FRAC_BITS_DEF;
        s = chan_sum[c] + gain - loss;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        chan_sum[c] = s;
      end
    end
    emits = h.last;
    if (h.last) begin
      if (hit_seen) begin
        if (regs.mode == 1'b0) begin
          {px.red, px.green, px.blue} = near_rgb;
        end else begin
          px.red   = clamp_channel(chan_sum[0]);
          px.green = clamp_channel(chan_sum[1]);
          px.blue  = clamp_channel(chan_sum[2]);
        end
        px.depth = near_dist[DIST_W-2:0];
        px.hit   = 1'b1;
      end
      clear_pixel_state();
    end
  endtask

  // Offers one record and queues its result; a typed expectation replaces the model's.
  task automatic offer_record(input hit_rec_t h, input bit typed, input pixel_t want);
    bit     emits;
    pixel_t px;
    if (take_break()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (take_break());
    end
    in_valid      <= 1'b1;
    in_entry_dist <= h.near;
    in_exit_dist  <= h.far;
    in_obj_red    <= h.red;
    in_obj_green  <= h.green;
    in_obj_blue   <= h.blue;
    in_last_obj   <= h.last;
    do @(posedge clk); while (!in_ready);
    resolve_record(h, emits, px);
    if (emits) pending_pixels.push_back(typed ? want : px);
  endtask

  task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input phr_cfg_t r);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_IDX_W-1:0]  bad;
    junk = CFG_DATA_W'($urandom);
    bad  = CFG_IDX_W'($urandom_range(int'(REG_MAXC) + 1, (1 << CFG_IDX_W) - 1));
    // An index past the last register must leave every register alone.
    put_cfg(bad, junk);
    put_cfg(REG_MODE, {junk[15:1], r.mode});
    put_cfg(REG_CONC, r.conc);
    put_cfg(REG_LOSS, r.loss);
    put_cfg(REG_MAXC, {junk[7:0], r.maxc});
    cfg_valid <= 1'b0;
    regs = r;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // Records that close no pixel leave nothing to wait on, so let them drain.
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input logic [31:0] near, input logic [31:0] far,
                         input logic [23:0] rgb, input bit last, input bit typed,
                         input logic [23:0] want_rgb, input logic [30:0] want_depth,
                         input bit want_hit);
    plan_row_t row;
    row            = '0;
    row.rec.near   = near;
    row.rec.far    = far;
    {row.rec.red, row.rec.green, row.rec.blue} = rgb;
    row.rec.last   = last;
    row.typed      = typed;
    {row.want.red, row.want.green, row.want.blue} = want_rgb;
    row.want.depth = want_depth;
    row.want.hit   = want_hit;
    plan_rows.push_back(row);
  endtask

  task automatic add_cfg_row(input phr_cfg_t r);
    plan_row_t row;
    row          = '0;
    row.set_regs = 1'b1;
    row.regs     = r;
    plan_rows.push_back(row);
  endtask

  function automatic logic [COL_W-1:0] random_colour();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return COL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic hit_rec_t random_record(input logic [31:0] prev);
    hit_rec_t h;
    case ($urandom_range(0, 9))
      0:       h.near = 32'd0;
      1:       h.near = 32'h8000_0000 | $urandom;
      2:       h.near = 32'h7FFF_FFFF;
      3:       h.near = 32'd1;
      4:       h.near = prev;
      5, 6:    h.near = $urandom_range(1, 32'h00FF_FFFF);
      default: h.near = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: h.far = h.near + $urandom_range(0, 32'h000F_FFFF);
      6, 7:             h.far = h.near - $urandom_range(0, 32'h00FF_FFFF);
      8:                h.far = $urandom;
      default:          h.far = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    h.red   = random_colour();
    h.green = random_colour();
    h.blue  = random_colour();
    h.last  = 1'b0;
    return h;
  endfunction

  // Random pixels; the quota may cut the final pixel short, leaving it open for the next
  // register setting.
  task automatic run_phase(input int quota);
    int          sent;
    int          len;
    int          k;
    hit_rec_t    h;
    logic [31:0] prev;
    sent = 0;
    while (sent < quota) begin
      len  = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      prev = 32'd1;
      for (k = 0; k < len && sent < quota; k++) begin
        h      = random_record(prev);
        h.last = (k == len - 1);
        prev   = h.near;
        offer_record(h, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_asked != stall_served) begin
      stall_served <= stall_asked;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  always @(posedge clk) begin : check_results
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) flag_mismatch("red", out_red, want.red);
        if (out_green !== want.green) flag_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) flag_mismatch("blue", out_blue, want.blue);
        if (out_depth !== want.depth) flag_mismatch("depth", out_depth, want.depth);
        if (out_any_hit !== want.hit) flag_mismatch("any_hit", out_any_hit, want.hit);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    phr_cfg_t r;
    hit_rec_t h;
    int       k;
    regs = '{1'b0, 16'd256, 16'd655, 8'd255};
    clear_pixel_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values, nearest-hit mode.
    add_row(32'h0000_0000, 32'h0000_1000, 24'hFFFFFF, 1, 1, 24'h000000, 31'd0, 0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 24'hAA550F, 1, 1, 24'h000000, 31'd0, 0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF0080, 1, 1, 24'hFF0080, 31'h7FFF_FFFF, 1);
    add_row(32'h0000_0001, 32'h0000_0002, 24'h123456, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'h0000_0001, 32'h0000_0009, 24'h9ABCDE, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'h0003_0000, 32'h0004_0000, 24'hEEEEEE, 1, 1, 24'h123456, 31'd1, 1);
    add_row(32'h0064_0000, 32'h0065_0000, 24'h112233, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'h0032_0000, 32'h0033_0000, 24'h445566, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'hFFFF_FFFB, 32'h0000_0010, 24'h778899, 1, 1, 24'h445566, 31'h0032_0000, 1);
    // Compositing with default factors.
    add_cfg_row('{1'b1, 16'd256, 16'd655, 8'd255});
    add_row(32'hFFFF_FFFF, 32'h0000_0005, 24'hFFFFFF, 1, 1, 24'h000000, 31'd0, 0);
    add_row(32'h0000_0001, 32'h7FFF_FFFF, 24'hFFFFFF, 1, 1, 24'hFFFFFF, 31'd1, 1);
    add_row(32'h0000_0001, 32'h7FFF_FFFF, 24'h000000, 1, 1, 24'h000000, 31'd1, 1);
    // Most negative thickness turns the loss into a large gain.
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 24'h000000, 1, 1, 24'hFFFFFF, 31'h7FFF_FFFF, 1);
    add_row(32'h0001_0000, 32'h0005_0000, 24'h804020, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'h0000_8000, 32'h0000_4000, 24'h10F070, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'h0000_0000, 32'h0000_1234, 24'hFFFFFF, 1, 0, 24'h0, 31'd0, 0);
    // Colours above the full-scale value make the difference negative.
    add_cfg_row('{1'b1, 16'hFFFF, 16'hFFFF, 8'h10});
    add_row(32'h0000_1000, 32'h0000_2000, 24'hFF8008, 1, 0, 24'h0, 31'd0, 0);
    add_row(32'h0000_0100, 32'h0000_0000, 24'h00FF10, 0, 0, 24'h0, 31'd0, 0);
    add_row(32'h0000_0002, 32'h0000_0003, 24'h202020, 1, 0, 24'h0, 31'd0, 0);
    add_cfg_row('{1'b1, 16'h0000, 16'h0000, 8'h00});
    add_row(32'h0000_0005, 32'h0000_0064, 24'hFFFFFF, 1, 1, 24'h000000, 31'd5, 1);
    // The mode switches in the middle of a pixel; the last record decides it.
    add_row(32'h0000_0007, 32'h0000_0008, 24'h010203, 0, 0, 24'h0, 31'd0, 0);
    add_cfg_row('{1'b0, 16'd256, 16'd655, 8'd255});
    add_row(32'h0000_0009, 32'h0000_000A, 24'hAABBCC, 1, 1, 24'h010203, 31'd7, 1);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].set_regs) begin
        wait_quiet();
        load_regs(plan_rows[i].regs);
      end else begin
        offer_record(plan_rows[i].rec, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p)
        0: r = '{1'b1, 16'hFFFF, 16'hFFFF, 8'hFF};
        1: r = '{1'b1, 16'h0000, 16'h0000, 8'h00};
        default: begin
          r.mode = (p % 3 != 2);
          r.conc = pick_word();
          r.loss = pick_word();
          r.maxc = 8'(pick_word());
        end
      endcase
      load_regs(r);
      calm = (p == 4);
      if (p == 2) stall_asked++;
      if (p == 0) begin
        // Gains push each sum past the top; the losses that follow only bring it below
        // zero when the sum was held at the limit.
        for (k = 0; k < SAT_UP + SAT_DOWN; k++) begin
          h = '0;
          if (k < SAT_UP) begin
            h.near = 32'h7FFF_FFFF;
            h.far  = 32'h8000_0000;
          end else begin
            h.near = 32'd1;
            h.far  = 32'h7FFF_FFFF;
          end
          h.last = (k == SAT_UP + SAT_DOWN - 1);
          offer_record(h, 1'b0, '0);
        end
        run_phase(40);
      end else begin
        run_phase(70);
      end
    end

    wait_quiet();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/phr_pkg.sv
rtl/core/phr_cfg_regs.sv
rtl/core/phr_ctrl.sv
rtl/core/phr_datapath.sv
rtl/core/pixel_hit_resolve.sv
tb/pixel_hit_resolve_test.sv
